/* hdl/ppd_pkg.sv */
// Shared types and constants for the pulse pair preamble and byte decoder.
package ppd_pkg;

  localparam int unsigned WIDTH_W   = 16;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned BYTES_W   = 6;
  localparam int unsigned HELD_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    MODE_HUNT     = 2'd0,
    MODE_PREAMBLE = 2'd1,
    MODE_DATA     = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    EV_SYNC    = 2'd0,
    EV_BYTE    = 2'd1,
    EV_PARTIAL = 2'd2
  } event_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_GAP_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PREAMBLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES    = 3'd4;

  localparam logic [WIDTH_W-1:0] RST_PAUSE_MIN    = 16'd0;
  localparam logic [WIDTH_W-1:0] RST_PAUSE_MAX    = 16'd0;
  localparam logic [WIDTH_W-1:0] RST_END_GAP_MIN  = 16'hFFFF;
  localparam logic [COUNT_W-1:0] RST_MAX_PREAMBLE = 8'd255;
  localparam logic [BYTES_W-1:0] RST_MAX_BYTES    = 6'd30;

  localparam logic [HELD_W-1:0] FULL_BYTE_BITS = 4'd8;

endpackage

/* hdl/pulse_pair_preamble_and_byte_decoder.sv */
// Pulse pair preamble hunter and byte assembler, top level.
//
// in_*  : one (high width, low width) pulse pair per item.
// out_* : sync marks, full bytes and the final partial byte of a frame;
//         tuser carries the kind, tlast marks the item that closes a frame.
// cfg_* : register writes, taken at any edge with cfg_we high; write only
//         while no item is in flight.
// An accepted item sits in the input register, where the window compares
// and the bit shift are worked out against the decoder state; when the item
// advances, a result, if it gives one, is registered in the output register.
// One item is taken every cycle while the receiver does not stall. The input
// register and the output register decouple the two sides: when the receiver
// stalls, one finished result and one more item are held, and in_tready drops
// only once both are full. Reset (rst_n low, synchronous) empties both
// registers, returns the decoder to hunting for a reference pair and
// restores the register defaults.
module pulse_pair_preamble_and_byte_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] high_width, [31:16] low_width
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] byte_value, [11:8] bit_count, rest zero
  output logic [1:0]  out_tuser,  // [1:0] event_res
  output logic        out_tlast,  // frame_end
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned W  = ppd_pkg::WIDTH_W;
  localparam int unsigned PW = W + 3;

  function automatic logic within_ref(input logic [W-1:0] w, input logic [W-1:0] r);
    logic [PW-1:0] w5;
    logic [PW-1:0] r4;
    logic [PW-1:0] r6;
    w5 = {1'b0, w, 2'b00} + {3'b000, w};
    r4 = {1'b0, r, 2'b00};
    r6 = {1'b0, r, 2'b00} + {2'b00, r, 1'b0};
    return (w5 >= r4) && (w5 <= r6);
  endfunction

  // configuration
  logic [W-1:0]                 pause_min_r, pause_max_r, end_gap_min_r;
  logic [ppd_pkg::COUNT_W-1:0]  max_preamble_r;
  logic [ppd_pkg::BYTES_W-1:0]  max_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pause_min_r    <= ppd_pkg::RST_PAUSE_MIN;
      pause_max_r    <= ppd_pkg::RST_PAUSE_MAX;
      end_gap_min_r  <= ppd_pkg::RST_END_GAP_MIN;
      max_preamble_r <= ppd_pkg::RST_MAX_PREAMBLE;
      max_bytes_r    <= ppd_pkg::RST_MAX_BYTES;
    end else if (cfg_we) begin
      case (cfg_addr)
        ppd_pkg::CFG_PAUSE_MIN:    pause_min_r    <= cfg_wdata;
        ppd_pkg::CFG_PAUSE_MAX:    pause_max_r    <= cfg_wdata;
        ppd_pkg::CFG_END_GAP_MIN:  end_gap_min_r  <= cfg_wdata;
        ppd_pkg::CFG_MAX_PREAMBLE: max_preamble_r <= cfg_wdata[ppd_pkg::COUNT_W-1:0];
        ppd_pkg::CFG_MAX_BYTES:    max_bytes_r    <= cfg_wdata[ppd_pkg::BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic         s1_valid_r, s1_valid_nxt;
  logic [W-1:0] s1_high_r, s1_low_r;
  logic         advance;
  logic         in_accept;

  assign advance   = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_accept) begin
      s1_high_r <= in_tdata[W-1:0];
      s1_low_r  <= in_tdata[2*W-1:W];
    end
  end

  // decoder state
  ppd_pkg::mode_t              mode_r, mode_nxt;
  logic [W-1:0]                ref_high_r, ref_high_nxt;
  logic [W-1:0]                ref_low_r, ref_low_nxt;
  logic [ppd_pkg::COUNT_W-1:0] match_count_r, match_count_nxt;
  logic [7:0]                  shift_bits_r, shift_bits_nxt;
  logic [ppd_pkg::HELD_W-1:0]  bits_held_r, bits_held_nxt;
  logic [ppd_pkg::BYTES_W-1:0] bytes_done_r, bytes_done_nxt;

  logic                        res_valid;
  ppd_pkg::event_t             res_event;
  logic [7:0]                  res_byte;
  logic [ppd_pkg::HELD_W-1:0]  res_count;
  logic                        res_last;

  logic                        high_ok, low_ok, in_pause, end_gap;
  logic [ppd_pkg::COUNT_W:0]   match_inc;
  logic [7:0]                  shift_in;
  logic [ppd_pkg::HELD_W-1:0]  held_inc;
  logic [ppd_pkg::BYTES_W:0]   bytes_inc;
  logic                        len_done;

  assign high_ok   = within_ref(s1_high_r, ref_high_r);
  assign low_ok    = within_ref(s1_low_r, ref_low_r);
  assign in_pause  = (s1_low_r >= pause_min_r) && (s1_low_r <= pause_max_r);
  assign end_gap   = s1_low_r > end_gap_min_r;
  assign match_inc = {1'b0, match_count_r} + {{ppd_pkg::COUNT_W{1'b0}}, 1'b1};
  assign shift_in  = {shift_bits_r[6:0], (s1_high_r < s1_low_r)};
  assign held_inc  = bits_held_r + {{(ppd_pkg::HELD_W-1){1'b0}}, 1'b1};
  assign bytes_inc = {1'b0, bytes_done_r} + {{ppd_pkg::BYTES_W{1'b0}}, 1'b1};
  assign len_done  = bytes_inc > {1'b0, max_bytes_r};

  always_comb begin
    mode_nxt        = mode_r;
    ref_high_nxt    = ref_high_r;
    ref_low_nxt     = ref_low_r;
    match_count_nxt = match_count_r;
    shift_bits_nxt  = shift_bits_r;
    bits_held_nxt   = bits_held_r;
    bytes_done_nxt  = bytes_done_r;
    res_valid       = 1'b0;
    res_event       = ppd_pkg::EV_SYNC;
    res_byte        = '0;
    res_count       = '0;
    res_last        = 1'b0;
    case (mode_r)
      ppd_pkg::MODE_PREAMBLE: begin
        if (!high_ok) begin
          mode_nxt = ppd_pkg::MODE_HUNT;
        end else if (low_ok) begin
          if (match_inc > {1'b0, max_preamble_r}) begin
            mode_nxt = ppd_pkg::MODE_HUNT;
          end else begin
            match_count_nxt = match_inc[ppd_pkg::COUNT_W-1:0];
            res_valid       = 1'b1;
          end
        end else if (in_pause) begin
          match_count_nxt = match_inc[ppd_pkg::COUNT_W-1:0];
          shift_bits_nxt  = '0;
          bits_held_nxt   = '0;
          bytes_done_nxt  = '0;
          mode_nxt        = ppd_pkg::MODE_DATA;
        end else begin
          mode_nxt = ppd_pkg::MODE_HUNT;
        end
      end
      ppd_pkg::MODE_DATA: begin
        if (end_gap) begin
          res_valid      = 1'b1;
          res_event      = ppd_pkg::EV_PARTIAL;
          res_byte       = shift_bits_r;
          res_count      = bits_held_r;
          res_last       = 1'b1;
          shift_bits_nxt = '0;
          bits_held_nxt  = '0;
          bytes_done_nxt = '0;
          mode_nxt       = ppd_pkg::MODE_HUNT;
        end else if (held_inc >= ppd_pkg::FULL_BYTE_BITS) begin
          res_valid      = 1'b1;
          res_event      = ppd_pkg::EV_BYTE;
          res_byte       = shift_in;
          res_count      = ppd_pkg::FULL_BYTE_BITS;
          res_last       = len_done;
          shift_bits_nxt = '0;
          bits_held_nxt  = '0;
          if (len_done) begin
            bytes_done_nxt = '0;
            mode_nxt       = ppd_pkg::MODE_HUNT;
          end else begin
            bytes_done_nxt = bytes_inc[ppd_pkg::BYTES_W-1:0];
          end
        end else begin
          shift_bits_nxt = shift_in;
          bits_held_nxt  = held_inc;
        end
      end
      default: begin
        ref_high_nxt    = s1_high_r;
        ref_low_nxt     = s1_low_r;
        match_count_nxt = '0;
        mode_nxt        = ppd_pkg::MODE_PREAMBLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= ppd_pkg::MODE_HUNT;
      ref_high_r    <= '0;
      ref_low_r     <= '0;
      match_count_r <= '0;
      shift_bits_r  <= '0;
      bits_held_r   <= '0;
      bytes_done_r  <= '0;
    end else if (advance) begin
      mode_r        <= mode_nxt;
      ref_high_r    <= ref_high_nxt;
      ref_low_r     <= ref_low_nxt;
      match_count_r <= match_count_nxt;
      shift_bits_r  <= shift_bits_nxt;
      bits_held_r   <= bits_held_nxt;
      bytes_done_r  <= bytes_done_nxt;
    end
  end

  // result register
  logic                       out_valid_r, out_valid_nxt;
  ppd_pkg::event_t            out_event_r;
  logic [7:0]                 out_byte_r;
  logic [ppd_pkg::HELD_W-1:0] out_count_r;
  logic                       out_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (advance && res_valid) begin
      out_event_r <= res_event;
      out_byte_r  <= res_byte;
      out_count_r <= res_count;
      out_last_r  <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_event_r;
  assign out_tdata  = {4'b0000, out_count_r, out_byte_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_tvalid && !out_tready))
    else $error("input stalled while a register is free");

  a_sync_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ppd_pkg::EV_SYNC) |->
    (out_tdata == 16'd0 && !out_tlast))
    else $error("sync mark carries payload");

  a_full_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ppd_pkg::EV_BYTE) |->
    (out_tdata[11:8] == ppd_pkg::FULL_BYTE_BITS))
    else $error("full byte without eight bits");

  a_byte_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && mode_r == ppd_pkg::MODE_DATA && !end_gap &&
     bits_held_r == 4'd7) |=> (bits_held_r == 4'd0 && out_tvalid))
    else $error("completed byte not flushed");

  a_frame_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid && res_last) |=> (mode_r == ppd_pkg::MODE_HUNT))
    else $error("frame end did not return to hunt");
`endif

endmodule

/* verif/ppd_decode_checker.sv */
// Predicts decoder results from accepted pulse pairs and compares them with the output stream.
`timescale 1ns / 100ps

module ppd_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] high_width, [31:16] low_width
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [7:0] byte_value, [11:8] bit_count, rest zero
  input  logic [1:0]  out_tuser,  // [1:0] event_res
  input  logic        out_tlast,  // frame_end
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    ppd_pkg::event_t kind;
    logic [7:0]      value;
    logic [3:0]      nbits;
    logic            last;
  } decoded_t;

  decoded_t expected_events[$];
  decoded_t want;

  logic [ppd_pkg::WIDTH_W-1:0] pause_lo, pause_hi, gap_min;
  logic [ppd_pkg::COUNT_W-1:0] preamble_max;
  logic [ppd_pkg::BYTES_W-1:0] bytes_max;

  ppd_pkg::mode_t              mode;
  logic [ppd_pkg::WIDTH_W-1:0] ref_h, ref_l;
  logic [ppd_pkg::COUNT_W-1:0] match_cnt;
  logic [7:0]                  shreg;
  logic [ppd_pkg::HELD_W-1:0]  held;
  logic [ppd_pkg::BYTES_W-1:0] nbytes;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic near_ref(input logic [15:0] w, input logic [15:0] r);
    logic [18:0] w5, r4, r6;
    w5 = 19'(w) * 19'd5;
    r4 = 19'(r) * 19'd4;
    r6 = 19'(r) * 19'd6;
    return (w5 >= r4) && (w5 <= r6);
  endfunction

  task automatic clear_frame;
    shreg = '0;
    held = '0;
    nbytes = '0;
  endtask

  task automatic decode_pair(input logic [15:0] hw, input logic [15:0] lw);
    logic [8:0]                 next_match;
    logic [7:0]                 sh_next;
    logic [ppd_pkg::HELD_W-1:0] held_next;
    logic [6:0]                 byte_next;
    logic                       done;
    case (mode)
      ppd_pkg::MODE_PREAMBLE: begin
        next_match = {1'b0, match_cnt} + 9'd1;
        if (!near_ref(hw, ref_h)) begin
          mode = ppd_pkg::MODE_HUNT;
        end else if (near_ref(lw, ref_l)) begin
          if (next_match > {1'b0, preamble_max}) begin
            mode = ppd_pkg::MODE_HUNT;
          end else begin
            match_cnt = next_match[7:0];
            expected_events.push_back('{kind: ppd_pkg::EV_SYNC, value: 8'd0,
                                        nbits: 4'd0, last: 1'b0});
          end
        end else if (lw >= pause_lo && lw <= pause_hi) begin
          match_cnt = next_match[7:0];
          clear_frame();
          mode = ppd_pkg::MODE_DATA;
        end else begin
          mode = ppd_pkg::MODE_HUNT;
        end
      end
      ppd_pkg::MODE_DATA: begin
        if (lw > gap_min) begin
          expected_events.push_back('{kind: ppd_pkg::EV_PARTIAL, value: shreg,
                                      nbits: held, last: 1'b1});
          clear_frame();
          mode = ppd_pkg::MODE_HUNT;
        end else begin
          sh_next = {shreg[6:0], hw < lw};
          held_next = held + 4'd1;
          if (held_next >= ppd_pkg::FULL_BYTE_BITS) begin
            byte_next = {1'b0, nbytes} + 7'd1;
            done = byte_next > {1'b0, bytes_max};
            expected_events.push_back('{kind: ppd_pkg::EV_BYTE, value: sh_next,
                                        nbits: ppd_pkg::FULL_BYTE_BITS, last: done});
            shreg = '0;
            held = '0;
            nbytes = byte_next[5:0];
            if (done) begin
              clear_frame();
              mode = ppd_pkg::MODE_HUNT;
            end
          end else begin
            shreg = sh_next;
            held = held_next;
          end
        end
      end
      default: begin
        ref_h = hw;
        ref_l = lw;
        match_cnt = '0;
        mode = ppd_pkg::MODE_PREAMBLE;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pause_lo = ppd_pkg::RST_PAUSE_MIN;
      pause_hi = ppd_pkg::RST_PAUSE_MAX;
      gap_min = ppd_pkg::RST_END_GAP_MIN;
      preamble_max = ppd_pkg::RST_MAX_PREAMBLE;
      bytes_max = ppd_pkg::RST_MAX_BYTES;
      mode = ppd_pkg::MODE_HUNT;
      ref_h = '0;
      ref_l = '0;
      match_cnt = '0;
      clear_frame();
      expected_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          ppd_pkg::CFG_PAUSE_MIN:    pause_lo = cfg_wdata;
          ppd_pkg::CFG_PAUSE_MAX:    pause_hi = cfg_wdata;
          ppd_pkg::CFG_END_GAP_MIN:  gap_min = cfg_wdata;
          ppd_pkg::CFG_MAX_PREAMBLE: preamble_max = cfg_wdata[ppd_pkg::COUNT_W-1:0];
          ppd_pkg::CFG_MAX_BYTES:    bytes_max = cfg_wdata[ppd_pkg::BYTES_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        decode_pair(in_tdata[15:0], in_tdata[31:16]);
      end
      if (out_tvalid && out_tready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected item: kind %0d value %h bits %0d last %b", $time,
                   out_tuser, out_tdata[7:0], out_tdata[11:8], out_tlast);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (out_tuser !== want.kind || out_tdata[7:0] !== want.value ||
              out_tdata[11:8] !== want.nbits || out_tdata[15:12] !== 4'd0 ||
              out_tlast !== want.last) begin
            $display("%0t: mismatch: expected kind %0d value %h bits %0d last %b pad 0,",
                     $time, want.kind, want.value, want.nbits, want.last);
            $display("%0t:           got      kind %0d value %h bits %0d last %b pad %h",
                     $time, out_tuser, out_tdata[7:0], out_tdata[11:8], out_tlast,
                     out_tdata[15:12]);
            fail_count++;
          end
        end
      end
    end
    pending = expected_events.size();
  end

endmodule

/* verif/pulse_pair_preamble_and_byte_decoder_test.sv */
// Stimulus and verdict for the pulse pair preamble and byte decoder.
`timescale 1ns / 100ps

module pulse_pair_preamble_and_byte_decoder_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam logic [ppd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [15:0] high_width, [31:16] low_width
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] byte_value, [11:8] bit_count, rest zero
  logic [1:0]  out_tuser;  // [1:0] event_res
  logic        out_tlast;  // frame_end
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  int fail_count;
  int pending;
  int cycles;
  int items_sent;
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_cnt;
  bit hold_req;

  int unsigned cur_pmin, cur_pmax, cur_gap, cur_maxpre, cur_maxb;

  pulse_pair_preamble_and_byte_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  ppd_decode_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
        hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic logic [15:0] near_width(input int unsigned r);
    int unsigned lo, hi;
    lo = (4 * r + 4) / 5;
    hi = (6 * r) / 5;
    if (hi > 65535) hi = 65535;
    return 16'($urandom_range(hi, lo));
  endfunction

  task automatic send_pair(input logic [15:0] hw, input logic [15:0] lw);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {lw, hw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [ppd_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // drain, then reprogram every register and set the idling mix
  task automatic apply_phase(input int unsigned pmin, input int unsigned pmax,
                             input int unsigned gap, input int unsigned maxpre,
                             input int unsigned maxb, input int tx, input int rx);
    in_tvalid <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending != 0) @(posedge clk);
    cur_pmin = pmin;
    cur_pmax = pmax;
    cur_gap = gap;
    cur_maxpre = maxpre;
    cur_maxb = maxb;
    write_reg(ppd_pkg::CFG_PAUSE_MIN, 16'(pmin));
    write_reg(ppd_pkg::CFG_PAUSE_MAX, 16'(pmax));
    write_reg(ppd_pkg::CFG_END_GAP_MIN, 16'(gap));
    write_reg(ppd_pkg::CFG_MAX_PREAMBLE, {8'($urandom), 8'(maxpre)});
    write_reg(ppd_pkg::CFG_MAX_BYTES, {10'($urandom), 6'(maxb)});
    write_reg(CFG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
    tx_idle_pct = tx;
    rx_stall_pct = rx;
  endtask

  task automatic send_frame;
    int unsigned rh, rl, npre, nbits, cap, k;
    logic [15:0] h, l;
    rh = $urandom_range(2000, 10);
    rl = $urandom_range(2000, 10);
    send_pair(16'(rh), 16'(rl));
    npre = $urandom_range(12, 0);
    for (k = 0; k < npre; k++) begin
      h = near_width(rh);
      l = near_width(rl);
      if ($urandom_range(99) < 4) h = 16'(2 * rh + 1);
      send_pair(h, l);
    end
    if (cur_pmin <= cur_pmax) l = 16'($urandom_range(cur_pmax, cur_pmin));
    else l = 16'($urandom);
    send_pair(near_width(rh), l);
    if (cur_gap == 65535) begin
      nbits = 8 * (cur_maxb + 1);
    end else if ($urandom_range(3) == 0) begin
      cap = 8 * (cur_maxb + 2);
      if (cap > 64) cap = 64;
      nbits = $urandom_range(cap, 0);
    end else begin
      nbits = $urandom_range(20, 0);
    end
    for (k = 0; k < nbits; k++) begin
      l = 16'($urandom_range((cur_gap < 800) ? cur_gap : 800, 0));
      h = 16'($urandom_range(800, 0));
      send_pair(h, l);
    end
    if (cur_gap != 65535) send_pair(16'($urandom), 16'($urandom_range(65535, cur_gap + 1)));
  endtask

  task automatic random_traffic(input int target);
    int start, n, k;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(99) < 15) begin
        n = $urandom_range(4, 1);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(1)) send_pair(16'($urandom), 16'($urandom));
          else send_pair(16'($urandom_range(3000, 0)), 16'($urandom_range(3000, 0)));
        end
      end else begin
        send_frame();
      end
    end
  endtask

  initial begin
    int k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    hold_req = 1'b0;
    items_sent = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero reference, window edges, preamble limit, pause, bits, gap ends
    apply_phase(3000, 5000, 8000, 3, 1, 0, 0);
    send_pair(16'd0, 16'd0);
    send_pair(16'd0, 16'd0);
    send_pair(16'd1, 16'd0);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'd52428, 16'd52428);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'd100, 16'd100);
    send_pair(16'd120, 16'd80);
    send_pair(16'd100, 16'd4000);
    send_pair(16'd0, 16'd8000);
    send_pair(16'd8000, 16'd0);
    send_pair(16'd5, 16'd5);
    send_pair(16'd4, 16'd5);
    send_pair(16'hFFFF, 16'd0);
    send_pair(16'd0, 16'd1);
    send_pair(16'd7, 16'd300);
    send_pair(16'd300, 16'd7);
    send_pair(16'd0, 16'd8001);
    send_pair(16'd100, 16'd100);
    send_pair(16'd100, 16'd2000);
    send_pair(16'd100, 16'd100);
    send_pair(16'd100, 16'd3000);
    send_pair(16'd1, 16'd2);
    send_pair(16'd0, 16'hFFFF);

    // default register values, frame closed by byte count
    apply_phase(0, 0, 65535, 255, 30, 0, 28);
    send_frame();

    apply_phase(3000, 5000, 9000, 255, 30, 0, 0);
    hold_req = 1'b1;
    send_pair(16'd300, 16'd300);
    for (k = 0; k < 24; k++) send_pair(near_width(300), near_width(300));
    random_traffic(200);

    apply_phase(2500, 2600, 2700, 8, 2, 48, 0);
    random_traffic(200);
    apply_phase(3000, 65535, 6000, 0, 0, 0, 48);
    random_traffic(200);
    apply_phase(65535, 65535, 0, 1, 63, 28, 28);
    random_traffic(200);
    apply_phase(0, 65535, 65534, 255, 63, 28, 28);
    random_traffic(200);
    apply_phase(40000, 10, 1000, 255, 5, 48, 48);
    random_traffic(100);

    in_tvalid <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
